@@ rtl/lzrd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzrd_pkg
// Shared types and constants of the LZSS ring decoder: ring geometry,
// word layouts of both channels, register indexes and the ring command bundle.
// ----------------------------------------------------------------------------
package lzrd_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam logic [7:0]         FILL_RST  = 8'h20;
    localparam logic [RING_AW-1:0] START_RST = 12'hFEE;

    // match length is the low nibble plus this bias
    localparam logic [4:0] LEN_BIAS = 5'd3;

    // configuration register indexes
    localparam int         CFG_IDX_W     = 1;
    localparam int         CFG_DATA_W    = 12;
    localparam logic [0:0] CFG_FILL_BYTE = 1'b0;
    localparam logic [0:0] CFG_START_POS = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
    } t_out_word;

    // one cycle's request to the history ring
    typedef struct packed {
        logic               start;
        logic [RING_AW-1:0] start_pos;
        logic [7:0]         fill;
        logic               wr_en;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [RING_AW-1:0] rd_addr;
    } t_ring_cmd;

endpackage

@@ rtl/lzrd_ring.sv @@
// ----------------------------------------------------------------------------
// lzrd_ring
// 4096-byte history ring with its own write pointer. Entries not yet written
// in this stream read as the fill byte, tracked by a fill count from the
// stream's start position. A read of the entry written in the same cycle
// returns the new byte.
// ----------------------------------------------------------------------------
module lzrd_ring (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzrd_pkg::t_ring_cmd  i_cmd,
    output logic [7:0]           o_rd_data
);
    import lzrd_pkg::*;

    logic [7:0]         r_mem [RING_DEPTH];
    logic [7:0]         r_raw;
    logic [7:0]         r_fwd_data;
    logic               r_use_fwd;
    logic               r_use_fill;
    logic [7:0]         r_fill;
    logic [RING_AW-1:0] r_base;
    logic [RING_AW-1:0] r_wpos;
    logic [RING_AW:0]   r_cnt;

    logic [RING_AW-1:0] rd_dist;
    logic               rd_written;
    logic               rd_fwd;

    // entry is written iff its distance from the stream base is under the count
    assign rd_dist    = i_cmd.rd_addr - r_base;
    assign rd_written = {1'b0, rd_dist} < r_cnt;
    assign rd_fwd     = i_cmd.wr_en && (i_cmd.rd_addr == r_wpos);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_wpos] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_raw <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_fwd_data <= i_cmd.wr_data;
            r_use_fwd  <= rd_fwd;
            r_use_fill <= !rd_written;
        end
        if (i_cmd.start) begin
            r_fill <= i_cmd.fill;
            r_base <= i_cmd.start_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wpos <= START_RST;
        end else if (i_cmd.start) begin
            r_cnt  <= '0;
            r_wpos <= i_cmd.start_pos;
        end else if (i_cmd.wr_en) begin
            r_wpos <= r_wpos + 1'b1;
            // saturate once the whole ring holds stream data
            if (!r_cnt[RING_AW]) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_rd_data = r_use_fwd  ? r_fwd_data :
                       r_use_fill ? r_fill     : r_raw;

    a_start_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.start && i_cmd.wr_en))
        else $error("ring restart collides with a write");

    a_start_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.start && i_cmd.rd_en))
        else $error("ring restart collides with a read");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[RING_AW] |-> (r_cnt[RING_AW-1:0] == '0))
        else $error("fill count ran past the ring depth");

endmodule

@@ rtl/lzss_ring_decoder.sv @@
// ----------------------------------------------------------------------------
// lzss_ring_decoder
// LZSS decompressor over a 4096-byte history ring: flag bytes select literal
// bytes or two-byte references (12-bit offset, length 3 to 18).
//
//   channel  | direction | handshake                 | word
//   ---------+-----------+---------------------------+--------------------
//   in       | to block  | i_in_valid / o_in_stall   | i_in_data  (t_in_word)
//   out      | from block| o_out_valid / i_out_stall | o_out_data (t_out_word)
//   cfg      | to block  | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A flag or first reference byte is taken in idle, a literal goes through emit,
// a second reference byte starts a copy: one read of the ring's single registered
// read port, then 3..18 bytes at one per cycle while the output does not stall.
// Reset clears control and configuration state only; the ring is not swept, a fill count makes
// unwritten entries read as the fill byte, so a new stream starts at once.
// Output stalls hold the copy in place; the output register lets a new input
// word be taken while a result still waits.
// ----------------------------------------------------------------------------
module lzss_ring_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lzrd_pkg::t_in_word              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lzrd_pkg::t_out_word             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [lzrd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lzrd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lzrd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EMIT = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;

    logic [1:0]         r_state,     n_state;
    logic [3:0]         r_tok,       n_tok;
    logic [7:0]         r_flags,     n_flags;
    logic               r_await,     n_await;
    logic [7:0]         r_first,     n_first;
    logic               r_in_stream, n_in_stream;
    logic               r_last,      n_last;
    t_out_word          r_pend_word, n_pend_word;
    logic [RING_AW-1:0] r_src,       n_src;
    logic [4:0]         r_left,      n_left;
    logic               r_pend,      n_pend;
    t_out_word          r_out,       n_out;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_cfg_fill;
    logic [RING_AW-1:0] r_cfg_start;

    t_ring_cmd  ring_cmd;
    logic [7:0] ring_rd_data;
    logic       out_free;
    logic       in_acc;
    logic       copy_done;

    lzrd_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ring_cmd),
        .o_rd_data (ring_rd_data)
    );

    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign copy_done = (r_left == 5'd1);

    always_comb begin
        n_state     = r_state;
        n_tok       = r_tok;
        n_flags     = r_flags;
        n_await     = r_await;
        n_first     = r_first;
        n_in_stream = r_in_stream;
        n_last      = r_last;
        n_pend_word = r_pend_word;
        n_src       = r_src;
        n_left      = r_left;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        ring_cmd           = '0;
        ring_cmd.start_pos = r_cfg_start;
        ring_cmd.fill      = r_cfg_fill;
        ring_cmd.rd_addr   = r_src;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    ring_cmd.start = !r_in_stream;
                    n_in_stream    = 1'b1;
                    n_last         = i_in_data.stream_last;
                    if (r_tok[3]) begin
                        n_flags = i_in_data.in_byte;
                        n_tok   = 4'd0;
                    end else if (r_await) begin
                        n_src   = {i_in_data.in_byte[7:4], r_first};
                        n_left  = {1'b0, i_in_data.in_byte[3:0]} + LEN_BIAS;
                        n_await = 1'b0;
                        n_tok   = r_tok + 4'd1;
                        n_pend  = 1'b0;
                        n_state = S_COPY;
                    end else if (r_flags[r_tok[2:0]]) begin
                        n_pend_word.out_byte   = i_in_data.in_byte;
                        n_pend_word.byte_valid = 1'b1;
                        n_pend_word.run_last   = 1'b1;
                        n_pend_word.stream_end = i_in_data.stream_last;
                        n_tok   = r_tok + 4'd1;
                        n_state = S_EMIT;
                    end else begin
                        n_first = i_in_data.in_byte;
                        n_await = 1'b1;
                    end
                    if (i_in_data.stream_last) begin
                        // cut-off token: send a bare end marker
                        if (r_tok[3] || (!r_await && !r_flags[r_tok[2:0]])) begin
                            n_pend_word.out_byte   = 8'd0;
                            n_pend_word.byte_valid = 1'b0;
                            n_pend_word.run_last   = 1'b1;
                            n_pend_word.stream_end = 1'b1;
                            n_state = S_EMIT;
                        end
                        n_tok       = 4'd8;
                        n_flags     = 8'd0;
                        n_await     = 1'b0;
                        n_first     = 8'd0;
                        n_in_stream = 1'b0;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out            = r_pend_word;
                    n_out_valid      = 1'b1;
                    ring_cmd.wr_en   = r_pend_word.byte_valid;
                    ring_cmd.wr_data = r_pend_word.out_byte;
                    n_state          = S_IDLE;
                end
            end
            S_COPY: begin
                if (!r_pend) begin
                    ring_cmd.rd_en = 1'b1;
                    n_src  = r_src + 1'b1;
                    n_pend = 1'b1;
                end else if (out_free) begin
                    n_out.out_byte   = ring_rd_data;
                    n_out.byte_valid = 1'b1;
                    n_out.run_last   = copy_done;
                    n_out.stream_end = copy_done && r_last;
                    n_out_valid      = 1'b1;
                    ring_cmd.wr_en   = 1'b1;
                    ring_cmd.wr_data = ring_rd_data;
                    n_left           = r_left - 5'd1;
                    if (copy_done) begin
                        n_pend  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        // next source byte may be the one written right now
                        ring_cmd.rd_en = 1'b1;
                        n_src = r_src + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tok       <= 4'd8;
            r_flags     <= 8'd0;
            r_await     <= 1'b0;
            r_first     <= 8'd0;
            r_in_stream <= 1'b0;
            r_last      <= 1'b0;
            r_left      <= 5'd0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_fill  <= FILL_RST;
            r_cfg_start <= START_RST;
        end else begin
            r_state     <= n_state;
            r_tok       <= n_tok;
            r_flags     <= n_flags;
            r_await     <= n_await;
            r_first     <= n_first;
            r_in_stream <= n_in_stream;
            r_last      <= n_last;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILL_BYTE: r_cfg_fill  <= i_cfg_data[7:0];
                    CFG_START_POS: r_cfg_start <= i_cfg_data[RING_AW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_word <= n_pend_word;
        r_src       <= n_src;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_last_ends_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.stream_last) |=> (!r_in_stream && r_tok[3]))
        else $error("stream end did not return the parser to its start");

    a_pend_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_COPY))
        else $error("ring read pending outside a copy");

    a_copy_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_left != 5'd0))
        else $error("copy running with no bytes left");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.stream_end) |-> o_out_data.run_last)
        else $error("stream end word not marked as last of its run");

endmodule
